### rtl/pq_adc_pkg.sv
package pq_adc_pkg;

  // Fixed field widths.
  localparam int unsigned MAX_SUBSPACES = 8;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned SUBSPACE_W    = 3;
  localparam int unsigned DIST_W        = 32;
  localparam int unsigned ID_W          = 31;
  localparam int unsigned RESULT_W      = 32;
  localparam int unsigned CODES_W       = MAX_SUBSPACES * CODE_W;

  // Defaults for the top level parameters.
  localparam int unsigned DEF_SUBSPACES     = 8;
  localparam int unsigned DEF_CODEBOOK_SIZE = 256;

  localparam logic [DIST_W-1:0]   PAD_DIST_RESET = 32'h7FFF_FFFF;
  localparam logic [RESULT_W-1:0] RESULT_PAD     = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCORE = 1'b1
  } cmd_e;

  typedef logic [MAX_SUBSPACES-1:0][DIST_W-1:0] lane_vec_t;

  // Stage enables handed from the pipeline control to the merge tree.
  typedef struct packed {
    logic en_pair;
    logic en_out;
  } pipe_ctrl_t;

endpackage

### rtl/pq_adc_lane.sv
module pq_adc_lane
  import pq_adc_pkg::*;
#(
  parameter int unsigned CODEBOOK_SIZE = DEF_CODEBOOK_SIZE
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [CODE_W-1:0] wr_code_i,
  input  logic [DIST_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [CODE_W-1:0] rd_code_i,
  output logic [DIST_W-1:0] lane_val_o
);

  localparam int unsigned AW = $clog2(CODEBOOK_SIZE);

  logic [DIST_W-1:0] mem_q [CODEBOOK_SIZE];
  logic [DIST_W-1:0] rdata_q;
  logic              rd_hit_q;
  logic              wr_hit;
  logic              rd_hit;

  // Codes beyond the codebook select nothing.
  assign wr_hit = ({1'b0, wr_code_i} < (CODE_W + 1)'(CODEBOOK_SIZE));
  assign rd_hit = ({1'b0, rd_code_i} < (CODE_W + 1)'(CODEBOOK_SIZE));

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_hit) begin
      mem_q[wr_code_i[AW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q  <= mem_q[rd_code_i[AW-1:0]];
      rd_hit_q <= rd_hit;
    end
  end

  assign lane_val_o = rd_hit_q ? rdata_q : '0;

endmodule

### rtl/pq_adc_merge.sv
module pq_adc_merge
  import pq_adc_pkg::*;
(
  input  logic              clk_i,
  input  pipe_ctrl_t        ctrl_i,
  input  lane_vec_t         lane_val_i,
  output logic [DIST_W-1:0] sum_o
);

  localparam int unsigned PAIRS  = MAX_SUBSPACES / 2;
  localparam int unsigned PAIR_W = DIST_W + 1;
  localparam int unsigned SUM_W  = DIST_W + 3;

  logic [PAIRS-1:0][PAIR_W-1:0] pair_d, pair_q;
  logic [SUM_W-1:0]             total;
  logic [DIST_W-1:0]            sat;
  logic [DIST_W-1:0]            sum_q;

  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      pair_d[i] = {lane_val_i[2*i][DIST_W-1], lane_val_i[2*i]}
                + {lane_val_i[2*i+1][DIST_W-1], lane_val_i[2*i+1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_pair) begin
      pair_q <= pair_d;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < PAIRS; i++) begin
      total = total + {{(SUM_W - PAIR_W){pair_q[i][PAIR_W-1]}}, pair_q[i]};
    end
  end

  // The sum fits when the bits above the 32-bit sign all agree with it.
  always_comb begin
    if ((&total[SUM_W-1:DIST_W-1]) || !(|total[SUM_W-1:DIST_W-1])) begin
      sat = total[DIST_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat = {1'b1, {(DIST_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DIST_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_out) begin
      sum_q <= sat;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/pq_adc_distance_lookup.sv
// Channel   Direction  Handshake                    Payload
// request   in         in_valid_i / in_stall_o      command, table fields, score fields
// result    out        out_valid_o / out_stall_i    result_cell, result_offset, distance
// config    in         cfg_we_i                     cfg_wdata_i (padding distance)
//
// One request is taken per cycle while in_stall_o is low. A score request passes,
// once accepted, through the registered read of the per-subspace table memories,
// the pairwise adders and the final add and clamp, each of them a registered stage.
// A table write completes at its accept edge and gives no result.
// Reset clears the pipeline valids and sets the padding distance to its maximum;
// the table is not cleared, and every entry must be written before it is scored.
// A stall on the result side holds the output and lets empty stages fill, so the
// input stalls only when all three stages hold a result.
module pq_adc_distance_lookup
  import pq_adc_pkg::*;
#(
  parameter int unsigned SUBSPACES     = DEF_SUBSPACES,
  parameter int unsigned CODEBOOK_SIZE = DEF_CODEBOOK_SIZE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DIST_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [SUBSPACE_W-1:0] table_subspace_i,
  input  logic [CODE_W-1:0]     table_code_i,
  input  logic [DIST_W-1:0]     table_value_i,
  input  logic [CODES_W-1:0]    codes_i,
  input  logic                  code_valid_i,
  input  logic [ID_W-1:0]       cell_id_i,
  input  logic [ID_W-1:0]       vector_offset_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RESULT_W-1:0]   result_cell_o,
  output logic [RESULT_W-1:0]   result_offset_o,
  output logic [DIST_W-1:0]     distance_o
);

  logic [DIST_W-1:0] padding_q;

  // Valid, padding flag and pass-through ids for the three stages.
  logic            v1_q, v2_q, v3_q;
  logic            pad1_q, pad2_q, pad3_q;
  logic [ID_W-1:0] cell1_q, cell2_q, cell3_q;
  logic [ID_W-1:0] off1_q, off2_q, off3_q;

  logic       en1, en2, en3;
  logic       accept;
  logic       is_write;
  logic       is_score;
  pipe_ctrl_t ctrl;
  lane_vec_t  lane_val;
  logic [DIST_W-1:0] sum;

  // A stage loads when it is empty or when its content moves on.
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign is_write   = accept && (command_i == CMD_WRITE);
  assign is_score   = accept && (command_i == CMD_SCORE);

  assign ctrl.en_pair = en2;
  assign ctrl.en_out  = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padding_q <= PAD_DIST_RESET;
    end else if (cfg_we_i) begin
      padding_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= is_score;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pad1_q  <= !code_valid_i;
      cell1_q <= cell_id_i;
      off1_q  <= vector_offset_i;
    end
    if (en2) begin
      pad2_q  <= pad1_q;
      cell2_q <= cell1_q;
      off2_q  <= off1_q;
    end
    if (en3) begin
      pad3_q  <= pad2_q;
      cell3_q <= cell2_q;
      off3_q  <= off2_q;
    end
  end

  // One table memory per subspace; subspaces beyond the configured count add zero.
  for (genvar b = 0; b < MAX_SUBSPACES; b++) begin : g_lane
    if (b < SUBSPACES) begin : g_used
      pq_adc_lane #(
        .CODEBOOK_SIZE(CODEBOOK_SIZE)
      ) u_lane (
        .clk_i     (clk_i),
        .wr_en_i   (is_write && (table_subspace_i == SUBSPACE_W'(b))),
        .wr_code_i (table_code_i),
        .wr_data_i (table_value_i),
        .rd_en_i   (en1),
        .rd_code_i (codes_i[CODE_W*b +: CODE_W]),
        .lane_val_o(lane_val[b])
      );
    end else begin : g_unused
      assign lane_val[b] = '0;
    end
  end

  pq_adc_merge u_merge (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .lane_val_i(lane_val),
    .sum_o     (sum)
  );

  assign out_valid_o     = v3_q;
  assign result_cell_o   = pad3_q ? RESULT_PAD : {1'b0, cell3_q};
  assign result_offset_o = pad3_q ? RESULT_PAD : {1'b0, off3_q};
  assign distance_o      = pad3_q ? padding_q : sum;

endmodule

### rtl/pq_adc_checker.sv
module pq_adc_checker
  import pq_adc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [DIST_W-1:0]     cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  command_i,
  input logic [SUBSPACE_W-1:0] table_subspace_i,
  input logic [CODE_W-1:0]     table_code_i,
  input logic [DIST_W-1:0]     table_value_i,
  input logic [CODES_W-1:0]    codes_i,
  input logic                  code_valid_i,
  input logic [ID_W-1:0]       cell_id_i,
  input logic [ID_W-1:0]       vector_offset_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [RESULT_W-1:0]   result_cell_o,
  input logic [RESULT_W-1:0]   result_offset_o,
  input logic [DIST_W-1:0]     distance_o
);

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_cell_o)
      && $stable(result_offset_o) && $stable(distance_o))
    else $error("stalled result changed");

  // The input side stalls only when a result is held at the output.
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // An accepted score with a free output reaches the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_SCORE))
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("score result did not arrive");

  // A padding result marks both ids; a real one has a non-negative cell id.
  a_pad_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_cell_o[RESULT_W-1] |-> result_offset_o == RESULT_PAD
      && result_cell_o == RESULT_PAD)
    else $error("padding ids inconsistent");

endmodule

bind pq_adc_distance_lookup pq_adc_checker u_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pq_adc_pkg::*;

  // The block is built with its default geometry: eight subspaces of 256 centroids.
  localparam int unsigned SUBSPACES     = DEF_SUBSPACES;
  localparam int unsigned CODEBOOK_SIZE = DEF_CODEBOOK_SIZE;
  localparam int unsigned TABLE_DEPTH   = SUBSPACES * CODEBOOK_SIZE;

  // Random requests per phase. With the directed rows this gives about 650 requests.
  localparam int unsigned PHASE_COUNT    = 6;
  localparam int unsigned PHASE_REQUESTS = 105;
  // Settle time after the last result; a safe margin for the pipeline to empty.
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT    = 200_000;

  // One request as seen on the input channel.
  typedef struct {
    cmd_e                  command;
    logic [SUBSPACE_W-1:0] subspace;
    logic [CODE_W-1:0]     code;
    logic [DIST_W-1:0]     value;
    logic [CODES_W-1:0]    codes;
    logic                  code_valid;
    logic [ID_W-1:0]       cell_id;
    logic [ID_W-1:0]       offset;
  } lookup_req_t;

  // One score result as seen on the output channel.
  typedef struct packed {
    logic [RESULT_W-1:0] cell_id;
    logic [RESULT_W-1:0] offset;
    logic [DIST_W-1:0]   distance;
  } score_result_t;

  // A directed row carries a request and, where it is obvious, the result typed in.
  typedef struct {
    lookup_req_t   req;
    bit            has_known;
    score_result_t known;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [DIST_W-1:0]     cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  command_i;
  logic [SUBSPACE_W-1:0] table_subspace_i;
  logic [CODE_W-1:0]     table_code_i;
  logic [DIST_W-1:0]     table_value_i;
  logic [CODES_W-1:0]    codes_i;
  logic                  code_valid_i;
  logic [ID_W-1:0]       cell_id_i;
  logic [ID_W-1:0]       vector_offset_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [RESULT_W-1:0]   result_cell_o;
  logic [RESULT_W-1:0]   result_offset_o;
  logic [DIST_W-1:0]     distance_o;

  // Shadow copy of the distance table and of the padding distance register.
  logic [DIST_W-1:0] table_shadow [TABLE_DEPTH];
  logic [DIST_W-1:0] pad_shadow;

  // Entries written since reset. Scores only select codes from these lists, since
  // reading an entry that was never written is outside the contract of the block.
  bit                written_entry [TABLE_DEPTH];
  logic [CODE_W-1:0] written_codes [MAX_SUBSPACES][$];

  // Score results still owed by the block, oldest first.
  score_result_t pending_scores_q [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  pq_adc_distance_lookup #(
    .SUBSPACES    (SUBSPACES),
    .CODEBOOK_SIZE(CODEBOOK_SIZE)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .table_subspace_i(table_subspace_i),
    .table_code_i    (table_code_i),
    .table_value_i   (table_value_i),
    .codes_i         (codes_i),
    .code_valid_i    (code_valid_i),
    .cell_id_i       (cell_id_i),
    .vector_offset_i (vector_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_cell_o   (result_cell_o),
    .result_offset_o (result_offset_o),
    .distance_o      (distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sums the table entries selected by the packed codes and clamps the full
  // precision sum to 32 signed bits once, at the end. Codes outside the codebook
  // and bytes beyond the configured subspaces add nothing.
  function automatic logic [DIST_W-1:0] clamped_code_sum(input logic [CODES_W-1:0] codes);
    longint      acc;
    int unsigned code;
    acc = 0;
    for (int b = 0; b < SUBSPACES && b < MAX_SUBSPACES; b++) begin
      code = int'(codes[CODE_W*b +: CODE_W]);
      if (code < CODEBOOK_SIZE) begin
        acc += longint'($signed(table_shadow[b*CODEBOOK_SIZE + code]));
      end
    end
    if (acc > 64'sh7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    if (acc < -64'sh8000_0000) begin
      return 32'h8000_0000;
    end
    return acc[DIST_W-1:0];
  endfunction

  // Applies one accepted request to the shadow state. Returns 1 with the expected
  // result for a score request, 0 for a table write.
  function automatic bit predict_lookup(input lookup_req_t r, output score_result_t res);
    int unsigned idx;
    res = '0;
    if (r.command == CMD_WRITE) begin
      if (r.subspace < SUBSPACES && r.code < CODEBOOK_SIZE) begin
        idx = r.subspace * CODEBOOK_SIZE + r.code;
        table_shadow[idx] = r.value;
        if (!written_entry[idx]) begin
          written_entry[idx] = 1'b1;
          written_codes[r.subspace].push_back(r.code);
        end
      end
      return 1'b0;
    end
    if (!r.code_valid) begin
      // Padding reports -1 for both ids and the configured distance.
      res.cell_id  = RESULT_PAD;
      res.offset   = RESULT_PAD;
      res.distance = pad_shadow;
    end else begin
      res.cell_id  = {1'b0, r.cell_id};
      res.offset   = {1'b0, r.offset};
      res.distance = clamped_code_sum(r.codes);
    end
    return 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return DIST_W'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Every field is filled, the unused ones with noise, since the block must
  // ignore them. A real score only selects entries that hold a written value.
  function automatic lookup_req_t random_request();
    lookup_req_t r;
    r.command    = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_SCORE;
    r.subspace   = SUBSPACE_W'($urandom_range(0, SUBSPACES - 1));
    if ($urandom_range(0, 4) == 0) begin
      r.code = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      r.code = CODE_W'($urandom_range(0, CODEBOOK_SIZE - 1));
    end
    r.value      = random_distance();
    r.codes      = {$urandom, $urandom};
    r.code_valid = ($urandom_range(0, 99) >= 12);
    r.cell_id    = random_id();
    r.offset     = random_id();
    if (r.command == CMD_SCORE && r.code_valid) begin
      for (int b = 0; b < SUBSPACES; b++) begin
        r.codes[CODE_W*b +: CODE_W] =
          written_codes[b][$urandom_range(0, written_codes[b].size() - 1)];
      end
    end
    return r;
  endfunction

  function automatic lookup_req_t table_write(input int unsigned sub, input int unsigned code,
                                              input logic [DIST_W-1:0] value);
    lookup_req_t r;
    r.command    = CMD_WRITE;
    r.subspace   = SUBSPACE_W'(sub);
    r.code       = CODE_W'(code);
    r.value      = value;
    r.codes      = {$urandom, $urandom};
    r.code_valid = 1'($urandom_range(0, 1));
    r.cell_id    = ID_W'($urandom);
    r.offset     = ID_W'($urandom);
    return r;
  endfunction

  function automatic lookup_req_t score_vector(input logic [CODES_W-1:0] codes,
                                               input logic code_valid,
                                               input logic [ID_W-1:0] cell_id,
                                               input logic [ID_W-1:0] offset);
    lookup_req_t r;
    r.command    = CMD_SCORE;
    r.subspace   = SUBSPACE_W'($urandom_range(0, 7));
    r.code       = CODE_W'($urandom_range(0, 255));
    r.value      = $urandom;
    r.codes      = codes;
    r.code_valid = code_valid;
    r.cell_id    = cell_id;
    r.offset     = offset;
    return r;
  endfunction

  // Presents one request and holds it until the block takes it. The stall is
  // sampled at the falling edge: it only changes after a rising edge, so this is
  // the value that the next rising edge sees, free of any race with the block.
  // On return the caller sits at the accepting edge with valid still high.
  task automatic send_request(input lookup_req_t r, input bit has_known,
                              input score_result_t known);
    score_result_t predicted;
    bit            stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= r.command;
    table_subspace_i <= r.subspace;
    table_code_i     <= r.code;
    table_value_i    <= r.value;
    codes_i          <= r.codes;
    code_valid_i     <= r.code_valid;
    cell_id_i        <= r.cell_id;
    vector_offset_i  <= r.offset;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    // The shadow state advances for every accepted request, even where the
    // expected result was typed in by hand.
    if (predict_lookup(r, predicted)) begin
      pending_scores_q.push_back(has_known ? known : predicted);
    end
  endtask

  // Drops valid and waits until every owed result has arrived, then lets the
  // pipeline settle so that the block is idle.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_scores_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_padding(input logic [DIST_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pad_shadow   = value;
  endtask

  function automatic void compare_field(input string field, input logic [31:0] expected,
                                        input logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, expected, actual);
      fail_count++;
    end
  endfunction

  // Result side. The stall is drawn anew after every rising edge; a result
  // shown with valid high and stall low at the falling edge is taken at the
  // next rising edge, so it is checked here.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin : result_monitor
    score_result_t expected;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_scores_q.size() == 0) begin
          $display("%0t: result with none expected: cell %h, offset %h, distance %h",
                   $time, result_cell_o, result_offset_o, distance_o);
          fail_count++;
        end else begin
          expected = pending_scores_q.pop_front();
          compare_field("result_cell", expected.cell_id, result_cell_o);
          compare_field("result_offset", expected.offset, result_offset_o);
          compare_field("distance", expected.distance, distance_o);
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    directed_row_t     rows [$];
    logic [DIST_W-1:0] phase_pad [PHASE_COUNT];

    fail_count       = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 47;
    pad_shadow       = PAD_DIST_RESET;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    command_i        <= CMD_WRITE;
    table_subspace_i <= '0;
    table_code_i     <= '0;
    table_value_i    <= '0;
    codes_i          <= '0;
    code_valid_i     <= 1'b0;
    cell_id_i        <= '0;
    vector_offset_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Padding right after reset shows the reset padding distance
    // and must not touch the table, which is still empty.
    rows.push_back('{score_vector(64'h0123_4567_89AB_CDEF, 1'b0, '1, '0), 1'b1,
                     {RESULT_PAD, RESULT_PAD, PAD_DIST_RESET}});
    // The largest and the smallest distance in every subspace, at the last and
    // the first centroid code.
    for (int b = 0; b < SUBSPACES; b++) begin
      rows.push_back('{table_write(b, 8'hFF, 32'h7FFF_FFFF), 1'b0, '0});
    end
    for (int b = 0; b < SUBSPACES; b++) begin
      rows.push_back('{table_write(b, 8'h00, 32'h8000_0000), 1'b0, '0});
    end
    // Positive overflow of the sum clamps to the largest distance.
    rows.push_back('{score_vector('1, 1'b1, '1, '1), 1'b1,
                     {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}});
    // Negative overflow clamps to the smallest distance.
    rows.push_back('{score_vector('0, 1'b1, '0, '0), 1'b1,
                     {32'h0000_0000, 32'h0000_0000, 32'h8000_0000}});
    // Four largest and four smallest entries: the clamp applies only at the end,
    // so the intermediate overflow cancels out to minus four units.
    rows.push_back('{score_vector(64'h00FF_00FF_00FF_00FF, 1'b1, 31'd1, 31'd2), 1'b1,
                     {32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFC}});
    // Fractional entries mixed with the extremes.
    rows.push_back('{table_write(3, 8'h5A, 32'h0001_0000), 1'b0, '0});
    rows.push_back('{table_write(5, 8'hA5, 32'hFFFF_8000), 1'b0, '0});
    rows.push_back('{score_vector(64'h0000_A5FF_5A00_FFFF, 1'b1, 31'h1234_5678,
                                  31'h7654_3210), 1'b0, '0});
    // Padding ignores the table even where its codes point at written entries.
    rows.push_back('{score_vector('1, 1'b0, '0, '1), 1'b1,
                     {RESULT_PAD, RESULT_PAD, PAD_DIST_RESET}});
    foreach (rows[i]) begin
      send_request(rows[i].req, rows[i].has_known, rows[i].known);
    end

    // Random part. Each phase starts from an idle block with a new padding
    // distance: both extremes, zero, minus one unit and random values.
    phase_pad[0] = 32'h8000_0000;
    phase_pad[1] = 32'h0000_0000;
    phase_pad[2] = 32'h7FFF_FFFF;
    phase_pad[3] = $urandom;
    phase_pad[4] = 32'hFFFF_FFFF;
    phase_pad[5] = $urandom;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // The sender idles lightly against a busy receiver, then the other way
      // round, then both run flat out.
      send_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 47 : 0;
      recv_idle_pct = (phase < 2) ? 47 : (phase < 4) ? 18 : 0;
      drain_pipeline();
      write_padding(phase_pad[phase]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
    end

    drain_pipeline();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
